### rtl/nir_pkg.sv
// Shared types and constants of the NEC IR pulse decoder.
// Depends on nothing; every other file of the block imports it.
package nir_pkg;

    // Field widths.
    localparam int PULSE_W  = 18;
    localparam int CODE_W   = 32;
    localparam int BTN_W    = 2;
    localparam int ACT_W    = 3;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;

    // Register indexes on the configuration port (byte address is four times this).
    localparam logic [REG_IDX_W-1:0] REG_LEADER_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPACE_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPACE_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MAX    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_MIN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_MAX = 3'd7;

    // Register reset values.
    localparam logic [PULSE_W-1:0] RST_LEADER_MIN = 18'd1000;
    localparam logic [PULSE_W-1:0] RST_LEADER_MAX = 18'd10000;
    localparam logic [PULSE_W-1:0] RST_SPACE_MIN  = 18'd200;
    localparam logic [PULSE_W-1:0] RST_SPACE_MAX  = 18'd5000;
    localparam logic [PULSE_W-1:0] RST_ZERO_MAX   = 18'd1200;
    localparam logic [PULSE_W-1:0] RST_ONE_MAX    = 18'd3050;
    localparam logic [PULSE_W-1:0] RST_REPEAT_MIN = 18'd95000;
    localparam logic [PULSE_W-1:0] RST_REPEAT_MAX = 18'd150000;

    // Fixed window of the repeat-frame tail that is ignored outside the data phase.
    localparam logic [PULSE_W-1:0] TAIL_LO = 18'd2000;
    localparam logic [PULSE_W-1:0] TAIL_HI = 18'd3000;

    // Button states.
    localparam logic [BTN_W-1:0] BTN_RELEASED = 2'd0;
    localparam logic [BTN_W-1:0] BTN_PRESSED  = 2'd1;
    localparam logic [BTN_W-1:0] BTN_HELD     = 2'd2;

    // Actions.
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FWD_FAST = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FWD_NORM = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FWD_SLOW = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BCK_FAST = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BCK_NORM = 3'd5;
    localparam logic [ACT_W-1:0] ACT_BCK_SLOW = 3'd6;

    // Known remote codes.
    localparam logic [CODE_W-1:0] KEY_FWD_FAST = 32'd16722135;
    localparam logic [CODE_W-1:0] KEY_FWD_NORM = 32'd16754775;
    localparam logic [CODE_W-1:0] KEY_FWD_SLOW = 32'd16738455;
    localparam logic [CODE_W-1:0] KEY_BCK_FAST = 32'd16713975;
    localparam logic [CODE_W-1:0] KEY_BCK_NORM = 32'd16746615;
    localparam logic [CODE_W-1:0] KEY_BCK_SLOW = 32'd16730295;

    // Window registers as seen by the classifier.
    typedef struct packed {
        logic [PULSE_W-1:0] leader_min;
        logic [PULSE_W-1:0] leader_max;
        logic [PULSE_W-1:0] space_min;
        logic [PULSE_W-1:0] space_max;
        logic [PULSE_W-1:0] zero_max;
        logic [PULSE_W-1:0] one_max;
        logic [PULSE_W-1:0] repeat_min;
        logic [PULSE_W-1:0] repeat_max;
    } cfg_t;

    // Window hits of one interval, the word that travels through the queue.
    typedef struct packed {
        logic rep;      // repeat-frame window
        logic tail;     // repeat-tail window
        logic leader;   // leader window
        logic space;    // start-space window
        logic zero;     // bit zero window
        logic one;      // bit one window
    } class_t;

    // Maps a latched code to its action.
    function automatic logic [ACT_W-1:0] map_action(input logic [CODE_W-1:0] c);
        logic [ACT_W-1:0] a;
        case (c)
            KEY_FWD_FAST: a = ACT_FWD_FAST;
            KEY_FWD_NORM: a = ACT_FWD_NORM;
            KEY_FWD_SLOW: a = ACT_FWD_SLOW;
            KEY_BCK_FAST: a = ACT_BCK_FAST;
            KEY_BCK_NORM: a = ACT_BCK_NORM;
            KEY_BCK_SLOW: a = ACT_BCK_SLOW;
            default:      a = ACT_NONE;
        endcase
        return a;
    endfunction

endpackage

### rtl/nir_cfg.sv
// Window registers of the NEC IR pulse decoder behind an APB-style port.
// Depends on nir_pkg.
module nir_cfg
    import nir_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;
    logic [PULSE_W-1:0]   wval;
    logic [PULSE_W-1:0]   rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];
    assign wval   = pwdata[PULSE_W-1:0];

    // Register writes in the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader_min <= RST_LEADER_MIN;
            cfg_reg.leader_max <= RST_LEADER_MAX;
            cfg_reg.space_min  <= RST_SPACE_MIN;
            cfg_reg.space_max  <= RST_SPACE_MAX;
            cfg_reg.zero_max   <= RST_ZERO_MAX;
            cfg_reg.one_max    <= RST_ONE_MAX;
            cfg_reg.repeat_min <= RST_REPEAT_MIN;
            cfg_reg.repeat_max <= RST_REPEAT_MAX;
        end else if (wr_en) begin
            case (idx)
                REG_LEADER_MIN: cfg_reg.leader_min <= wval;
                REG_LEADER_MAX: cfg_reg.leader_max <= wval;
                REG_SPACE_MIN:  cfg_reg.space_min  <= wval;
                REG_SPACE_MAX:  cfg_reg.space_max  <= wval;
                REG_ZERO_MAX:   cfg_reg.zero_max   <= wval;
                REG_ONE_MAX:    cfg_reg.one_max    <= wval;
                REG_REPEAT_MIN: cfg_reg.repeat_min <= wval;
                REG_REPEAT_MAX: cfg_reg.repeat_max <= wval;
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (idx)
            REG_LEADER_MIN: rval = cfg_reg.leader_min;
            REG_LEADER_MAX: rval = cfg_reg.leader_max;
            REG_SPACE_MIN:  rval = cfg_reg.space_min;
            REG_SPACE_MAX:  rval = cfg_reg.space_max;
            REG_ZERO_MAX:   rval = cfg_reg.zero_max;
            REG_ONE_MAX:    rval = cfg_reg.one_max;
            REG_REPEAT_MIN: rval = cfg_reg.repeat_min;
            REG_REPEAT_MAX: rval = cfg_reg.repeat_max;
            default:        rval = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-PULSE_W){1'b0}}, rval};
    assign cfg    = cfg_reg;

endmodule

### rtl/nir_front.sv
// Front end of the NEC IR pulse decoder: takes intervals and sorts them into windows.
// Depends on nir_pkg.
module nir_front
    import nir_pkg::*;
(
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PULSE_W-1:0] s_pulse_us,
    input  cfg_t               cfg,
    input  logic               q_full,
    output logic               q_push,
    output class_t             q_word
);

    logic [PULSE_W-1:0] p;

    assign p       = s_pulse_us;
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Window compares; an inverted window simply never hits.
    always_comb begin
        q_word.rep    = (p >= cfg.repeat_min) && (p <= cfg.repeat_max);
        q_word.tail   = (p >= TAIL_LO) && (p <= TAIL_HI);
        q_word.leader = (p >= cfg.leader_min) && (p <= cfg.leader_max);
        q_word.space  = (p >= cfg.space_min) && (p <= cfg.space_max);
        q_word.zero   = (p != '0) && (p <= cfg.zero_max);
        q_word.one    = (p > cfg.zero_max) && (p <= cfg.one_max);
    end

endmodule

### rtl/nir_queue.sv
// Two-word queue between the classifier and the frame decoder.
// Depends on nir_pkg.
module nir_queue
    import nir_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  class_t wr_word,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output class_t rd_word
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    class_t            mem [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign rd_word = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    // Storage words carry no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/nir_back.sv
// Back end of the NEC IR pulse decoder: frame state machine, code latch and output word.
// Depends on nir_pkg.
module nir_back
    import nir_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  class_t            q_word,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_frame_done,
    output logic              m_repeat_seen,
    output logic [CODE_W-1:0] m_code,
    output logic [BTN_W-1:0]  m_button_state,
    output logic [ACT_W-1:0]  m_action
);

    localparam int CntW = $clog2(FRAME_BITS + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_DATA
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [CODE_W-1:0] shift_reg, shift_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic [CntW-1:0]   cnt_inc;
    logic [CODE_W-1:0] last_reg, last_next;
    logic [BTN_W-1:0]  press_reg, press_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic              valid_reg, valid_next;
    logic              done_reg, done_next;
    logic              rep_reg, rep_next;

    // A word is taken from the queue whenever the output slot is free or emptying.
    assign q_pop   = !q_empty && (!valid_reg || m_ready);
    assign cnt_inc = cnt_reg + CntW'(1);

    // Next-state logic of the frame decoder.
    always_comb begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        press_next = press_reg;
        act_next   = act_reg;
        done_next  = done_reg;
        rep_next   = rep_reg;
        valid_next = valid_reg && !m_ready;
        if (q_pop) begin
            valid_next = 1'b1;
            done_next  = 1'b0;
            rep_next   = 1'b0;
            if (q_word.rep) begin
                // A repeat frame wins in every phase.
                press_next = BTN_HELD;
                act_next   = map_action(last_reg);
                rep_next   = 1'b1;
            end else if (phase_reg != PH_DATA && q_word.tail) begin
                // Repeat tail outside a data run is dropped.
            end else begin
                case (phase_reg)
                    PH_START: begin
                        if (q_word.space) begin
                            phase_next = PH_DATA;
                            shift_next = '0;
                            cnt_next   = '0;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        if (q_word.zero || q_word.one) begin
                            shift_next = {shift_reg[CODE_W-2:0], q_word.one};
                            cnt_next   = cnt_inc;
                            if (cnt_inc == CntW'(FRAME_BITS)) begin
                                last_next  = shift_next;
                                act_next   = map_action(shift_next);
                                phase_next = PH_IDLE;
                                press_next = BTN_PRESSED;
                                done_next  = 1'b1;
                            end
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_IDLE: begin
                        if (q_word.leader) begin
                            phase_next = PH_START;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Decoder state and the registered output word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            cnt_reg   <= '0;
            last_reg  <= '0;
            press_reg <= BTN_RELEASED;
            act_reg   <= ACT_NONE;
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
            rep_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            press_reg <= press_next;
            act_reg   <= act_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
            rep_reg   <= rep_next;
        end
    end

    // State only moves when a new word is loaded, so it doubles as the output word.
    assign m_valid        = valid_reg;
    assign m_frame_done   = done_reg;
    assign m_repeat_seen  = rep_reg;
    assign m_code         = last_reg;
    assign m_button_state = press_reg;
    assign m_action       = act_reg;

endmodule

### rtl/nec_ir_pulse_decoder.sv
// Top level of the NEC IR pulse decoder: window registers, classifier, queue, frame decoder.
// Depends on nir_pkg, nir_cfg, nir_front, nir_queue and nir_back.
//
//   Channel   Direction  Handshake          Contents
//   s_        in         s_valid/s_ready    s_pulse_us, one interval per word
//   m_        out        m_valid/m_ready    frame_done, repeat_seen, code, button_state, action
//   apb       in         psel/penable       eight 18-bit window registers at 4*index
//
// With m_ready high, one word per cycle is taken and one result per cycle is given.
// Each result passes through registers after its interval is accepted: the classifier writes
// the queue, and the frame decoder then loads the output register from the queue head.
// Reset is synchronous and active low; it empties the queue and restores all state
// and window registers. While m_ready is low the two-word queue fills and s_ready drops.
module nec_ir_pulse_decoder
    import nir_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PULSE_W-1:0] s_pulse_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_done,
    output logic               m_repeat_seen,
    output logic [CODE_W-1:0]  m_code,
    output logic [BTN_W-1:0]   m_button_state,
    output logic [ACT_W-1:0]   m_action,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t   cfg;
    class_t push_word;
    class_t head_word;
    logic   q_push, q_pop, q_full, q_empty;

    nir_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nir_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pulse_us (s_pulse_us),
        .cfg        (cfg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_word     (push_word)
    );

    nir_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_word (push_word),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_word (head_word)
    );

    nir_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_word         (head_word),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_done   (m_frame_done),
        .m_repeat_seen  (m_repeat_seen),
        .m_code         (m_code),
        .m_button_state (m_button_state),
        .m_action       (m_action)
    );

endmodule

### rtl/nir_checker.sv
// Port-level checks of the NEC IR pulse decoder and the bind that attaches them.
// Depends on nir_pkg and nec_ir_pulse_decoder.
module nir_checker
    import nir_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_frame_done,
    input logic              m_repeat_seen,
    input logic [CODE_W-1:0] m_code,
    input logic [BTN_W-1:0]  m_button_state
);

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code) && $stable(m_button_state))
        else $error("stalled result word changed");

    // A word is either a completed frame or a repeat, never both.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_done && m_repeat_seen))
        else $error("frame done and repeat in one word");

    // A completed frame shows the button pressed.
    a_done_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_button_state == BTN_PRESSED)
        else $error("frame done without pressed state");

    // A repeat shows the button held.
    a_rep_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_repeat_seen |-> m_button_state == BTN_HELD)
        else $error("repeat without held state");

endmodule

bind nec_ir_pulse_decoder nir_checker u_nir_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_frame_done   (m_frame_done),
    .m_repeat_seen  (m_repeat_seen),
    .m_code         (m_code),
    .m_button_state (m_button_state)
);

### test/tb.sv
`timescale 1ns / 1ps
// Testbench of the NEC IR pulse decoder: a self-checking bench with its own frame decoder.
// Depends on nir_pkg and nec_ir_pulse_decoder.

module tb;
    import nir_pkg::*;

    localparam int FRAME_BITS      = 32;
    localparam int PULSE_MAX       = 2 ** PULSE_W - 1;
    localparam int NUM_WINDOW_REGS = 8;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 300000;

    // Known keys and their actions, lowest index in the low bits.
    localparam logic [6*CODE_W-1:0] KEY_LIST = {KEY_BCK_SLOW, KEY_BCK_NORM, KEY_BCK_FAST,
                                                KEY_FWD_SLOW, KEY_FWD_NORM, KEY_FWD_FAST};
    localparam logic [6*ACT_W-1:0] ACT_LIST = {ACT_BCK_SLOW, ACT_BCK_NORM, ACT_BCK_FAST,
                                               ACT_FWD_SLOW, ACT_FWD_NORM, ACT_FWD_FAST};

    typedef enum logic [1:0] {PH_IDLE, PH_START, PH_DATA} decode_phase_t;
    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_mode_t;

    typedef struct packed {
        logic              frame_done;
        logic              repeat_seen;
        logic [CODE_W-1:0] code;
        logic [BTN_W-1:0]  button;
        logic [ACT_W-1:0]  action;
    } ir_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [PULSE_W-1:0] s_pulse_us = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_frame_done;
    logic               m_repeat_seen;
    logic [CODE_W-1:0]  m_code;
    logic [BTN_W-1:0]   m_button_state;
    logic [ACT_W-1:0]   m_action;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Decoder state as the bench expects it.
    cfg_t               win;
    decode_phase_t      phase;
    logic [CODE_W-1:0]  shift_reg;
    logic [5:0]         bit_count;
    logic [CODE_W-1:0]  latched_code;
    logic [BTN_W-1:0]   button;
    logic [ACT_W-1:0]   action_now;

    ir_result_t pending_results[$];
    int         mismatches = 0;
    int         pulses_sent = 0;
    int         burst_left = 0;
    int         cycle_count = 0;
    rx_mode_t   ready_mode = RX_STEADY;

    nec_ir_pulse_decoder #(.FRAME_BITS(FRAME_BITS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_pulse_us(s_pulse_us),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_frame_done(m_frame_done), .m_repeat_seen(m_repeat_seen), .m_code(m_code),
        .m_button_state(m_button_state), .m_action(m_action),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 aclk = ~aclk;

    // The receiver periodically switches to a randomly chosen stall pattern.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0) ready_mode <= rx_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            RX_STEADY:   m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_ready <= (cycle_count % 5 < 3);
            default:     m_ready <= (cycle_count % 6 == 0);
        endcase
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        mismatches++;
    endtask

    // Each result word is compared with the oldest expectation.
    always @(posedge aclk) begin : check_results
        ir_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", '0, m_code);
            end else begin
                want = pending_results.pop_front();
                if (m_frame_done !== want.frame_done)
                    report_mismatch("frame_done", want.frame_done, m_frame_done);
                if (m_repeat_seen !== want.repeat_seen)
                    report_mismatch("repeat_seen", want.repeat_seen, m_repeat_seen);
                if (m_code !== want.code)
                    report_mismatch("code", want.code, m_code);
                if (m_button_state !== want.button)
                    report_mismatch("button_state", want.button, m_button_state);
                if (m_action !== want.action)
                    report_mismatch("action", want.action, m_action);
            end
        end
    end

    function automatic logic [ACT_W-1:0] action_for_code(input logic [CODE_W-1:0] c);
        for (int i = 0; i < 6; i++)
            if (KEY_LIST[i*CODE_W +: CODE_W] == c) return ACT_LIST[i*ACT_W +: ACT_W];
        return ACT_NONE;
    endfunction

    function automatic logic [PULSE_W-1:0] window_field(input cfg_t c,
                                                        input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_LEADER_MIN: return c.leader_min;
            REG_LEADER_MAX: return c.leader_max;
            REG_SPACE_MIN:  return c.space_min;
            REG_SPACE_MAX:  return c.space_max;
            REG_ZERO_MAX:   return c.zero_max;
            REG_ONE_MAX:    return c.one_max;
            REG_REPEAT_MIN: return c.repeat_min;
            default:        return c.repeat_max;
        endcase
    endfunction

    function automatic cfg_t make_windows(input int lmin, input int lmax, input int smin,
                                          input int smax, input int zmax, input int omax,
                                          input int rmin, input int rmax);
        cfg_t c;
        c.leader_min = PULSE_W'(lmin);
        c.leader_max = PULSE_W'(lmax);
        c.space_min  = PULSE_W'(smin);
        c.space_max  = PULSE_W'(smax);
        c.zero_max   = PULSE_W'(zmax);
        c.one_max    = PULSE_W'(omax);
        c.repeat_min = PULSE_W'(rmin);
        c.repeat_max = PULSE_W'(rmax);
        return c;
    endfunction

    function automatic logic in_span(input logic [PULSE_W-1:0] p, input logic [PULSE_W-1:0] lo,
                                     input logic [PULSE_W-1:0] hi);
        return p >= lo && p <= hi;
    endfunction

    // Expected decoder state after reset.
    task automatic reset_decoder;
        win = make_windows(RST_LEADER_MIN, RST_LEADER_MAX, RST_SPACE_MIN, RST_SPACE_MAX,
                           RST_ZERO_MAX, RST_ONE_MAX, RST_REPEAT_MIN, RST_REPEAT_MAX);
        phase = PH_IDLE;
        shift_reg = '0;
        bit_count = '0;
        latched_code = '0;
        button = BTN_RELEASED;
        action_now = ACT_NONE;
    endtask

    // Advances the expected decoder by one interval and queues the result it gives.
    task automatic decode_interval(input logic [PULSE_W-1:0] p);
        ir_result_t r;
        logic       bit_ok;
        r.frame_done = 1'b0;
        r.repeat_seen = 1'b0;
        bit_ok = 1'b1;
        if (in_span(p, win.repeat_min, win.repeat_max)) begin
            button = BTN_HELD;
            action_now = action_for_code(latched_code);
            r.repeat_seen = 1'b1;
        end else if (phase != PH_DATA && in_span(p, TAIL_LO, TAIL_HI)) begin
            // Tail of a repeat frame: nothing changes.
        end else if (phase == PH_START) begin
            if (in_span(p, win.space_min, win.space_max)) begin
                phase = PH_DATA;
                shift_reg = '0;
                bit_count = '0;
            end else begin
                phase = PH_IDLE;
            end
        end else if (phase == PH_DATA) begin
            if (p != 0 && p <= win.zero_max) begin
                shift_reg = {shift_reg[CODE_W-2:0], 1'b0};
            end else if (p > win.zero_max && p <= win.one_max) begin
                shift_reg = {shift_reg[CODE_W-2:0], 1'b1};
            end else begin
                bit_ok = 1'b0;
                phase = PH_IDLE;
            end
            if (bit_ok) begin
                bit_count = bit_count + 1'b1;
                if (bit_count == FRAME_BITS) begin
                    latched_code = shift_reg;
                    action_now = action_for_code(shift_reg);
                    phase = PH_IDLE;
                    button = BTN_PRESSED;
                    r.frame_done = 1'b1;
                end
            end
        end else if (in_span(p, win.leader_min, win.leader_max)) begin
            phase = PH_START;
        end
        r.code = latched_code;
        r.button = button;
        r.action = action_now;
        pending_results.push_back(r);
    endtask

    // Sends one interval word. Words go out in bursts with random gaps between them.
    task automatic send_pulse(input logic [PULSE_W-1:0] pulse);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_pulse_us <= pulse;
        do @(posedge aclk); while (s_ready !== 1'b1);
        decode_interval(pulse);
        burst_left--;
        pulses_sent++;
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic finish_pending;
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [REG_IDX_W-1:0] idx, input logic [PULSE_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= PDATA_W'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (idx)
            REG_LEADER_MIN: win.leader_min = v;
            REG_LEADER_MAX: win.leader_max = v;
            REG_SPACE_MIN:  win.space_min = v;
            REG_SPACE_MAX:  win.space_max = v;
            REG_ZERO_MAX:   win.zero_max = v;
            REG_ONE_MAX:    win.one_max = v;
            REG_REPEAT_MIN: win.repeat_min = v;
            default:        win.repeat_max = v;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_window(input logic [REG_IDX_W-1:0] idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== PDATA_W'(window_field(win, idx)))
            report_mismatch("register readback", PDATA_W'(window_field(win, idx)), prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Loads a full window set once the decoder is idle, then reads it back.
    task automatic program_windows(input cfg_t c);
        finish_pending();
        for (int i = 0; i < NUM_WINDOW_REGS; i++)
            write_window(REG_IDX_W'(i), window_field(c, REG_IDX_W'(i)));
        for (int i = 0; i < NUM_WINDOW_REGS; i++)
            check_window(REG_IDX_W'(i));
    endtask

    function automatic logic [PULSE_W-1:0] pick_in(input int lo, input int hi);
        int a;
        int b;
        a = (lo > PULSE_MAX) ? PULSE_MAX : lo;
        b = (hi > PULSE_MAX) ? PULSE_MAX : hi;
        if (a >= b) return PULSE_W'(a);
        return PULSE_W'($urandom_range(b, a));
    endfunction

    // Tries to pick a leader or space length that is neither a repeat tail nor a repeat frame.
    function automatic logic [PULSE_W-1:0] pick_clear(input int lo, input int hi);
        logic [PULSE_W-1:0] v;
        v = pick_in(lo, hi);
        for (int t = 0; t < 8; t++) begin
            if (!in_span(v, TAIL_LO, TAIL_HI) && !in_span(v, win.repeat_min, win.repeat_max))
                break;
            v = pick_in(lo, hi);
        end
        return v;
    endfunction

    function automatic logic [PULSE_W-1:0] bit_pulse(input logic b);
        return b ? pick_in(win.zero_max + 1, win.one_max) : pick_in(1, win.zero_max);
    endfunction

    // Sends leader, space and the first bits of a code word, msb first. A frame cut short
    // ends with a zero word or a word above both bit windows, where they leave room above them.
    task automatic send_frame(input logic [CODE_W-1:0] word, input int nbits);
        int top;
        send_pulse(pick_clear(win.leader_min, win.leader_max));
        send_pulse(pick_clear(win.space_min, win.space_max));
        for (int i = 0; i < nbits; i++)
            send_pulse(bit_pulse(word[CODE_W-1-i]));
        if (nbits < FRAME_BITS) begin
            top = (win.zero_max > win.one_max) ? win.zero_max : win.one_max;
            send_pulse(($urandom_range(0, 1) == 0) ? '0 : pick_in(top + 1, PULSE_MAX));
        end
    endtask

    function automatic logic [CODE_W-1:0] random_code;
        if ($urandom_range(0, 2) == 0) return KEY_LIST[$urandom_range(0, 5)*CODE_W +: CODE_W];
        return $urandom;
    endfunction

    // Mostly whole frames with random content and repeats, the rest broken frames and noise.
    task automatic send_mixed_traffic(input int n);
        int stop_at;
        int pick;
        int v;
        stop_at = pulses_sent + n;
        while (pulses_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame(random_code(), FRAME_BITS);
                repeat ($urandom_range(0, 2)) begin
                    send_pulse(pick_in(win.repeat_min, win.repeat_max));
                    if ($urandom_range(0, 1) == 0) send_pulse(pick_in(TAIL_LO, TAIL_HI));
                end
            end else if (pick < 70) begin
                send_frame(random_code(), $urandom_range(0, FRAME_BITS - 1));
            end else if (pick < 85) begin
                send_pulse(PULSE_W'($urandom_range(0, PULSE_MAX)));
            end else begin
                // Just at or next to the edge of some window.
                v = window_field(win, REG_IDX_W'($urandom_range(0, NUM_WINDOW_REGS - 1)));
                v = v + $urandom_range(0, 2) - 1;
                send_pulse(pick_in((v < 0) ? 0 : v, (v < 0) ? 0 : v));
            end
        end
    endtask

    function automatic cfg_t random_windows;
        int lmin;
        int smin;
        int zmax;
        int rmin;
        lmin = $urandom_range(3001, 8000);
        smin = $urandom_range(3001, 4500);
        zmax = $urandom_range(300, 1500);
        rmin = $urandom_range(20000, 120000);
        return make_windows(lmin, lmin + $urandom_range(0, 5000), smin,
                            smin + $urandom_range(0, 2000), zmax,
                            zmax + $urandom_range(1, 2500), rmin,
                            rmin + $urandom_range(0, 100000));
    endfunction

    task automatic test_reset_values;
        for (int i = 0; i < NUM_WINDOW_REGS; i++)
            check_window(REG_IDX_W'(i));
    endtask

    task automatic test_special_cases;
        // In idle, zero, the largest interval, the tail window and near-miss leaders do nothing.
        send_pulse('0);
        send_pulse(PULSE_W'(PULSE_MAX));
        send_pulse(TAIL_LO);
        send_pulse(TAIL_HI);
        send_pulse(RST_LEADER_MIN - 1'b1);
        send_pulse(RST_LEADER_MAX + 1'b1);
        // A repeat before any frame holds the button with code zero and no action.
        send_pulse(RST_REPEAT_MIN);
        send_pulse(RST_REPEAT_MAX);
        send_pulse(RST_REPEAT_MIN - 1'b1);
        send_pulse(RST_REPEAT_MAX + 1'b1);
        // The tail is ignored after a leader; a short space returns to idle.
        send_pulse(RST_LEADER_MIN);
        send_pulse((TAIL_LO + TAIL_HI) / 2);
        send_pulse(RST_SPACE_MIN - 1'b1);
        // A zero interval aborts the data phase.
        send_pulse(RST_LEADER_MAX);
        send_pulse(RST_SPACE_MAX);
        send_pulse('0);
        // A long space returns to idle.
        send_pulse(RST_LEADER_MAX);
        send_pulse(RST_SPACE_MAX + 1'b1);
        // In data, a repeat keeps the phase, a tail length is a one bit, bit window edges
        // are read, and an interval above both windows aborts.
        send_pulse(RST_LEADER_MAX / 2);
        send_pulse(RST_SPACE_MIN);
        send_pulse(RST_REPEAT_MIN);
        send_pulse(18'd1);
        send_pulse(RST_ZERO_MAX);
        send_pulse(RST_ZERO_MAX + 1'b1);
        send_pulse(TAIL_LO);
        send_pulse(RST_ONE_MAX);
        send_pulse(RST_ONE_MAX + 1'b1);
    endtask

    // Each known key as a full frame, then held and followed by a repeat tail.
    task automatic test_known_codes;
        for (int k = 0; k < 6; k++) begin
            send_frame(KEY_LIST[k*CODE_W +: CODE_W], FRAME_BITS);
            send_pulse(pick_in(win.repeat_min, win.repeat_max));
            send_pulse(pick_in(TAIL_LO, TAIL_HI));
        end
    endtask

    task automatic test_window_extremes;
        // Leader, space and one windows widest, zero window empty, repeat window the top alone.
        program_windows(make_windows(0, PULSE_MAX, 0, PULSE_MAX, 0, PULSE_MAX,
                                     PULSE_MAX, PULSE_MAX));
        send_mixed_traffic(50);
        // Inverted windows never match, so the decoder stays idle.
        program_windows(make_windows(8000, 7000, 4000, 3500, PULSE_MAX, 0,
                                     RST_REPEAT_MAX, RST_REPEAT_MIN));
        send_mixed_traffic(50);
        // Single-value windows, and every nonzero bit below the top reads as zero.
        program_windows(make_windows(5000, 5000, PULSE_MAX, PULSE_MAX, PULSE_MAX - 1, 0, 0, 0));
        send_mixed_traffic(50);
    endtask

    task automatic test_random_windows;
        repeat (4) begin
            program_windows(random_windows());
            send_mixed_traffic(80);
        end
    endtask

    initial begin
        reset_decoder();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_special_cases();
        test_known_codes();
        test_window_extremes();
        test_random_windows();
        finish_pending();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/nir_pkg.sv
rtl/nir_cfg.sv
rtl/nir_front.sv
rtl/nir_queue.sv
rtl/nir_back.sv
rtl/nec_ir_pulse_decoder.sv
rtl/nir_checker.sv
test/tb.sv
